FILE: hw/rtl/degenerate_polygon_filter_macros.svh
// Assertion macros used by the checker file of the polygon filter.
`ifndef DEGENERATE_POLYGON_FILTER_MACROS_SVH
`define DEGENERATE_POLYGON_FILTER_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define DPF_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("polygon filter check failed");

// Clocked assertion that also holds across reset.
`define DPF_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("polygon filter check failed");

`endif

FILE: hw/rtl/dpf_pkg.sv
// Shared constants and types of the degenerate polygon filter.
package dpf_pkg;

  // Width of the corner and offset fields on the ports.
  localparam int FIELD_BITS = 24;
  // Saturation limit of the output offset counter.
  localparam logic [FIELD_BITS-1:0] OFFSET_MAX = {FIELD_BITS{1'b1}};

  // Default and upper bound of the polygon buffer size.
  localparam int MAX_CORNERS_DEFAULT = 16;
  localparam int MAX_CORNERS_LIMIT = 64;
  // Default stored width of a vertex index.
  localparam int INDEX_BITS_DEFAULT = 24;

  // Count field wide enough for any legal buffer size.
  localparam int CNT_BITS = $clog2(MAX_CORNERS_LIMIT + 1);

  // Depth of the result queue at the output.
  localparam int OUT_DEPTH = 4;

  // One kept polygon handed from the front to the back.
  typedef struct packed {
    logic                  bank;
    logic [CNT_BITS-1:0]   count;
    logic [FIELD_BITS-1:0] start;
  } dpf_desc_t;

  // One result word waiting at the output.
  typedef struct packed {
    logic [FIELD_BITS-1:0] vertex;
    logic                  first;
    logic [FIELD_BITS-1:0] start;
    logic                  last;
  } dpf_result_t;

endpackage

FILE: hw/rtl/dpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dpf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry into the output register.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/dpf_front.sv
// Front end: accepts corners, detects repeats and overflow, queues kept polygons.
module dpf_front #(
  parameter int MAX_CORNERS = dpf_pkg::MAX_CORNERS_DEFAULT,
  parameter int INDEX_BITS  = dpf_pkg::INDEX_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [dpf_pkg::FIELD_BITS-1:0]      vertex_index,
  input  logic                                end_of_polygon,
  input  logic                                push,
  output logic                                full,
  output logic                                wr_en,
  output logic [$clog2(MAX_CORNERS):0]        wr_addr,
  output logic [INDEX_BITS-1:0]               wr_data,
  output logic                                desc_valid,
  output dpf_pkg::dpf_desc_t                  desc,
  input  logic                                desc_done
);

  localparam int CW   = $clog2(MAX_CORNERS + 1);
  localparam int IW   = $clog2(MAX_CORNERS);
  localparam int FW   = dpf_pkg::FIELD_BITS;
  localparam int CNTB = dpf_pkg::CNT_BITS;

  // Corner cells of the polygon being collected, for repeat compare.
  logic [INDEX_BITS-1:0] cells [MAX_CORNERS];
  logic [CW-1:0]         count;
  logic                  ovf;

  // Second stage: one accepted corner with its compare results.
  logic                  b_valid;
  logic                  b_end;
  logic                  b_wr;
  logic                  b_ovf;
  logic [CW-1:0]         b_count;
  logic [IW-1:0]         b_idx;
  logic [INDEX_BITS-1:0] b_data;
  logic [MAX_CORNERS-1:0] b_match;

  logic                  rep_acc;
  logic                  wr_bank;
  logic [FW-1:0]         emitted;

  // Queue of kept polygons, two entries, one per corner bank.
  dpf_pkg::dpf_desc_t    q [2];
  logic                  q_head;
  logic [1:0]            q_cnt;

  logic                  accept;
  logic [FW+31:0]        v_wide;
  logic [INDEX_BITS-1:0] v;
  logic                  ovf_now;
  logic [MAX_CORNERS-1:0] match_now;
  logic                  rep;
  logic                  keep;
  logic [FW:0]           sum;
  logic [FW-1:0]         emitted_next;
  logic [1:0]            pending;
  logic                  q_tail;

  // Take the low index bits of the input word.
  assign v_wide  = {32'b0, vertex_index};
  assign v       = v_wide[INDEX_BITS-1:0];
  assign ovf_now = ovf || (count >= CW'(MAX_CORNERS));

  // Stall while both banks are held or about to be.
  assign pending = q_cnt + {1'b0, b_valid && b_end};
  assign full    = (pending >= 2'd2);
  assign accept  = push && !full;

  // Compare the new corner against every buffered corner.
  always_comb begin
    for (int k = 0; k < MAX_CORNERS; k++) begin
      match_now[k] = (CW'(k) < count) && (cells[k] == v);
    end
  end

  // Collect corners, reset the polygon on its end mark.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (accept) begin
      if (!ovf_now) begin
        cells[count[IW-1:0]] <= v;
      end
      if (end_of_polygon) begin
        count <= '0;
        ovf   <= 1'b0;
      end else begin
        count <= ovf_now ? count : count + CW'(1);
        ovf   <= ovf_now;
      end
    end
  end

  // Advance the corner into the second stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= accept;
    end
    if (accept) begin
      b_end   <= end_of_polygon;
      b_wr    <= !ovf_now;
      b_ovf   <= ovf_now;
      b_count <= ovf_now ? count : count + CW'(1);
      b_idx   <= count[IW-1:0];
      b_data  <= v;
      b_match <= match_now;
    end
  end

  // Decide keep or drop at the end of a polygon.
  assign rep  = rep_acc || (|b_match);
  assign keep = b_valid && b_end && !rep && !b_ovf;

  assign wr_en   = b_valid && b_wr;
  assign wr_addr = {wr_bank, b_idx};
  assign wr_data = b_data;

  // Add the kept corners to the offset, stop at the top.
  assign sum          = {1'b0, emitted} + (FW + 1)'(b_count);
  assign emitted_next = sum[FW] ? dpf_pkg::OFFSET_MAX : sum[FW-1:0];

  assign q_tail = q_head ^ q_cnt[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rep_acc <= 1'b0;
      wr_bank <= 1'b0;
      emitted <= '0;
      q_head  <= 1'b0;
      q_cnt   <= '0;
    end else begin
      if (b_valid) begin
        rep_acc <= b_end ? 1'b0 : rep;
      end
      if (keep) begin
        q[q_tail].bank  <= wr_bank;
        q[q_tail].count <= CNTB'(b_count);
        q[q_tail].start <= emitted;
        emitted         <= emitted_next;
        wr_bank         <= ~wr_bank;
      end
      if (desc_done) begin
        q_head <= ~q_head;
      end
      q_cnt <= q_cnt + {1'b0, keep} - {1'b0, desc_done};
    end
  end

  assign desc_valid = (q_cnt != 2'd0);
  assign desc       = q[q_head];

endmodule

FILE: hw/rtl/dpf_back.sv
// Back end: reads kept polygons from the corner RAM and queues result words.
module dpf_back #(
  parameter int MAX_CORNERS = dpf_pkg::MAX_CORNERS_DEFAULT,
  parameter int INDEX_BITS  = dpf_pkg::INDEX_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           desc_valid,
  input  dpf_pkg::dpf_desc_t             desc,
  output logic                           desc_done,
  output logic [$clog2(MAX_CORNERS):0]   rd_addr,
  input  logic [INDEX_BITS-1:0]          rd_data,
  output logic [dpf_pkg::FIELD_BITS-1:0] corner_vertex,
  output logic                           polygon_start,
  output logic [dpf_pkg::FIELD_BITS-1:0] start_offset,
  output logic                           last_of_run,
  output logic                           empty,
  input  logic                           pop
);

  localparam int CW = $clog2(MAX_CORNERS + 1);
  localparam int IW = $clog2(MAX_CORNERS);
  localparam int FW = dpf_pkg::FIELD_BITS;
  localparam int OD = dpf_pkg::OUT_DEPTH;
  localparam int PW = $clog2(OD);

  logic [IW-1:0]         j;
  logic                  rd_valid;
  logic                  rd_first;
  logic                  rd_last;
  logic [FW-1:0]         rd_start;

  dpf_pkg::dpf_result_t  fifo [OD];
  logic [PW-1:0]         f_head;
  logic [PW-1:0]         f_tail;
  logic [PW:0]           f_cnt;

  logic                  issue;
  logic                  is_last;
  logic                  pop_fire;
  logic [INDEX_BITS+FW-1:0] d_wide;

  // Issue a read only when the result queue has room for it.
  assign issue     = desc_valid && ((f_cnt + {{PW{1'b0}}, rd_valid}) < (PW + 1)'(OD));
  assign is_last   = ((CW'(j) + CW'(1)) == desc.count[CW-1:0]);
  assign desc_done = issue && is_last;
  assign rd_addr   = {desc.bank, j};

  // Step through the corners of the head polygon.
  always_ff @(posedge clk) begin
    if (rst) begin
      j        <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
      if (issue) begin
        j <= is_last ? '0 : j + IW'(1);
      end
    end
    if (issue) begin
      rd_first <= (j == '0);
      rd_last  <= is_last;
      rd_start <= desc.start;
    end
  end

  // Fit the stored index to the output field.
  assign d_wide = {{FW{1'b0}}, rd_data};

  assign pop_fire = pop && !empty;

  // Queue result words, hand out the oldest.
  always_ff @(posedge clk) begin
    if (rst) begin
      f_head <= '0;
      f_tail <= '0;
      f_cnt  <= '0;
    end else begin
      if (rd_valid) begin
        fifo[f_tail].vertex <= d_wide[FW-1:0];
        fifo[f_tail].first  <= rd_first;
        fifo[f_tail].start  <= rd_start;
        fifo[f_tail].last   <= rd_last;
        f_tail              <= f_tail + PW'(1);
      end
      if (pop_fire) begin
        f_head <= f_head + PW'(1);
      end
      f_cnt <= f_cnt + {{PW{1'b0}}, rd_valid} - {{PW{1'b0}}, pop_fire};
    end
  end

  assign empty         = (f_cnt == '0);
  assign corner_vertex = fifo[f_head].vertex;
  assign polygon_start = fifo[f_head].first;
  assign start_offset  = fifo[f_head].start;
  assign last_of_run   = fifo[f_head].last;

endmodule

FILE: hw/rtl/degenerate_polygon_filter.sv
// Top level of the degenerate polygon filter: front end, corner RAM, back end.
//
// Corners enter one per cycle through push/full while full is low. The front end
// compares each corner against the corners already held for its polygon (one
// comparator per buffer cell, results registered, then reduced) and writes it
// into one of two banks of the corner RAM. On the end mark a polygon with a
// repeated index or more than MAX_CORNERS corners is dropped; a kept one is queued
// with its saturated start offset, and the back end reads it out of the RAM into a
// four-word output queue, one result word per cycle while that queue has room. The
// two RAM banks let the next polygon fill while the last one drains. When the back
// end is idle, a kept polygon is decided and queued in the front end's second stage
// after its end mark is taken, the back end issues its first read, and the
// registered RAM data enters the output queue as its first result word. full rises
// while both banks hold polygons not yet read out, and for the cycle in which a
// polygon end is decided while the other bank still waits to be read out. No
// clearing pass follows reset.
module degenerate_polygon_filter #(
  parameter int MAX_CORNERS = dpf_pkg::MAX_CORNERS_DEFAULT,
  parameter int INDEX_BITS  = dpf_pkg::INDEX_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [dpf_pkg::FIELD_BITS-1:0] vertex_index,
  input  logic                           end_of_polygon,
  input  logic                           push,
  output logic                           full,
  output logic [dpf_pkg::FIELD_BITS-1:0] corner_vertex,
  output logic                           polygon_start,
  output logic [dpf_pkg::FIELD_BITS-1:0] start_offset,
  output logic                           last_of_run,
  output logic                           empty,
  input  logic                           pop
);

  localparam int AW = $clog2(MAX_CORNERS) + 1;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [INDEX_BITS-1:0] wr_data;
  logic [AW-1:0]         rd_addr;
  logic [INDEX_BITS-1:0] rd_data;
  logic                  desc_valid;
  dpf_pkg::dpf_desc_t    desc;
  logic                  desc_done;

  dpf_front #(
    .MAX_CORNERS (MAX_CORNERS),
    .INDEX_BITS  (INDEX_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .vertex_index   (vertex_index),
    .end_of_polygon (end_of_polygon),
    .push           (push),
    .full           (full),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .desc_valid     (desc_valid),
    .desc           (desc),
    .desc_done      (desc_done)
  );

  // Two banks, each rounded up to a power of two so that {bank, index} stays in range.
  dpf_ram #(
    .WIDTH (INDEX_BITS),
    .DEPTH (2 ** AW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  dpf_back #(
    .MAX_CORNERS (MAX_CORNERS),
    .INDEX_BITS  (INDEX_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .desc_valid    (desc_valid),
    .desc          (desc),
    .desc_done     (desc_done),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .corner_vertex (corner_vertex),
    .polygon_start (polygon_start),
    .start_offset  (start_offset),
    .last_of_run   (last_of_run),
    .empty         (empty),
    .pop           (pop)
  );

endmodule

FILE: hw/rtl/dpf_checker.sv
// Port-level checks of the polygon filter, bound to the top level.
`include "degenerate_polygon_filter_macros.svh"

module dpf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           full,
  input logic [dpf_pkg::FIELD_BITS-1:0] corner_vertex,
  input logic                           polygon_start,
  input logic [dpf_pkg::FIELD_BITS-1:0] start_offset,
  input logic                           last_of_run,
  input logic                           empty,
  input logic                           pop
);

  // Reset leaves no result word waiting.
  `DPF_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> empty)

  // Reset leaves the input open.
  `DPF_ASSERT_ALWAYS(a_reset_open, clk, rst |=> !full)

  // A waiting word that is not taken stays put.
  `DPF_ASSERT(a_hold_word, clk, rst, (!empty && !pop) |=> (!empty && $stable(corner_vertex)))

  // After the last corner of a polygon the next word opens a new polygon.
  `DPF_ASSERT(a_next_opens, clk, rst, (!empty && pop && last_of_run) |=> (empty || polygon_start))

  // Inside a polygon the start offset does not change and no new start shows.
  `DPF_ASSERT(a_offset_steady, clk, rst, (!empty && pop && !last_of_run) |=> (empty || (!polygon_start && start_offset == $past(start_offset))))

endmodule

bind degenerate_polygon_filter dpf_checker u_dpf_checker (
  .clk           (clk),
  .rst           (rst),
  .full          (full),
  .corner_vertex (corner_vertex),
  .polygon_start (polygon_start),
  .start_offset  (start_offset),
  .last_of_run   (last_of_run),
  .empty         (empty),
  .pop           (pop)
);
